### rtl/tdpt_pkg.sv
package tdpt_pkg;

    localparam int STEP_W = 3;

    typedef logic [STEP_W-1:0] t_step;

    // program steps
    localparam t_step STEP_ACCEPT   = 3'd0;
    localparam t_step STEP_SCREEN   = 3'd1;
    localparam t_step STEP_BOUND    = 3'd2;
    localparam t_step STEP_DIV_INIT = 3'd3;
    localparam t_step STEP_DIV_STEP = 3'd4;
    localparam t_step STEP_TEST     = 3'd5;
    localparam t_step STEP_NEXT     = 3'd6;
    localparam t_step STEP_OUT      = 3'd7;

    // jump conditions
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_REQ,
        COND_REJECT,
        COND_SQ_GT,
        COND_DIV_MORE,
        COND_REM_ZERO,
        COND_OUT_WAIT
    } t_cond;

    typedef struct packed {
        t_cond cond;
        t_step target;
        logic  in_ready;
        logic  load;
        logic  flag_set;
        logic  flag_clr;
        logic  div_init;
        logic  div_step;
        logic  inc_d;
        logic  out_valid;
    } t_ctrl;

    typedef struct packed {
        logic no_req;
        logic reject;
        logic sq_gt;
        logic div_more;
        logic rem_zero;
        logic out_wait;
    } t_status;

    function automatic t_ctrl rom_word(input t_step step);
        t_ctrl w;
        w = '0;
        unique case (step)
            STEP_ACCEPT: begin
                w.in_ready = 1'b1;
                w.load     = 1'b1;
                w.cond     = COND_NO_REQ;
                w.target   = STEP_ACCEPT;
            end
            STEP_SCREEN: begin
                w.flag_clr = 1'b1;
                w.cond     = COND_REJECT;
                w.target   = STEP_OUT;
            end
            STEP_BOUND: begin
                w.flag_set = 1'b1;
                w.cond     = COND_SQ_GT;
                w.target   = STEP_OUT;
            end
            STEP_DIV_INIT: begin
                w.div_init = 1'b1;
                w.cond     = COND_NEVER;
                w.target   = STEP_ACCEPT;
            end
            STEP_DIV_STEP: begin
                w.div_step = 1'b1;
                w.cond     = COND_DIV_MORE;
                w.target   = STEP_DIV_STEP;
            end
            STEP_TEST: begin
                w.flag_clr = 1'b1;
                w.cond     = COND_REM_ZERO;
                w.target   = STEP_OUT;
            end
            STEP_NEXT: begin
                w.inc_d    = 1'b1;
                w.cond     = COND_ALWAYS;
                w.target   = STEP_BOUND;
            end
            STEP_OUT: begin
                w.out_valid = 1'b1;
                w.cond      = COND_OUT_WAIT;
                w.target    = STEP_OUT;
            end
        endcase
        return w;
    endfunction

endpackage

### rtl/tdpt_seq.sv
module tdpt_seq import tdpt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    t_step r_step;
    t_step n_step;
    logic  take;

    always_comb begin
        o_ctrl = rom_word(r_step);
    end

    always_comb begin
        unique case (o_ctrl.cond)
            COND_NEVER:    take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_REQ:   take = i_status.no_req;
            COND_REJECT:   take = i_status.reject;
            COND_SQ_GT:    take = i_status.sq_gt;
            COND_DIV_MORE: take = i_status.div_more;
            COND_REM_ZERO: take = i_status.rem_zero;
            COND_OUT_WAIT: take = i_status.out_wait;
        endcase
        // fall-through from the output step wraps back to accept
        n_step = take ? o_ctrl.target : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_ACCEPT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

### rtl/trial_division_prime_test.sv
// Trial-division primality test. Each request carries one signed value; the
// block answers with one flag, 1 when the value is prime. Negative values, 0
// and 1 are rejected at the screen step and give 0. Otherwise divisors
// d = 2, 3, ... are tried while d*d <= value, the square kept by running sums.
// Each divisor passes the bound check, the divider setup, the bit-serial
// restoring remainder unit that takes one quotient bit per cycle, the zero
// test and the increment. One request is in flight at a time; the flag
// stays on o_prime_flag until the result is taken.
module trial_division_prime_test import tdpt_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_value_valid,
    output logic                   o_value_ready,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_result_valid,
    input  logic                   i_result_ready,
    output logic                   o_prime_flag
);

    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(W);

    t_ctrl   ctrl;
    t_status status;

    logic [W-1:0]     r_mag;
    logic [W-1:0]     r_d;
    logic [W:0]       r_sq;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_flag;

    logic [W:0] rem_sh;
    logic [W:0] rem_sub;
    logic       rem_ge;

    tdpt_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    // one restoring step: bring in the next dividend bit, subtract if it fits
    always_comb begin
        rem_sh  = {r_rem, r_quo[W-1]};
        rem_ge  = rem_sh >= {1'b0, r_d};
        rem_sub = rem_sh - {1'b0, r_d};
    end

    always_comb begin
        status.no_req   = !i_value_valid;
        status.reject   = r_mag[W-1] || (r_mag[W-1:1] == '0);
        status.sq_gt    = r_sq > {1'b0, r_mag};
        status.div_more = r_cnt != '0;
        status.rem_zero = r_rem == '0;
        status.out_wait = !i_result_ready;
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.load) begin
            r_mag <= i_value;
            r_d   <= W'(2);
            r_sq  <= (W+1)'(4);
        end
        if (ctrl.inc_d) begin
            r_d  <= r_d + 1'b1;
            r_sq <= r_sq + {r_d, 1'b1};
        end
        if (ctrl.div_init) begin
            r_rem <= '0;
            r_quo <= r_mag;
            r_cnt <= CNT_W'(W-1);
        end
        if (ctrl.div_step) begin
            // remainder stays below d, so the top bit is always clear
            r_rem <= rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
            r_quo <= {r_quo[W-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
        if (ctrl.flag_set) begin
            r_flag <= 1'b1;
        end
        if (ctrl.flag_clr) begin
            r_flag <= 1'b0;
        end
    end

    assign o_value_ready  = ctrl.in_ready;
    assign o_result_valid = ctrl.out_valid;
    assign o_prime_flag   = r_flag;

endmodule
